@@ rtl/core/btmx_pkg.sv @@
// Shared constants and types for the maximum-XOR binary trie.
package btmx_pkg;

	localparam int KEY_BITS   = 31;
	localparam int NODE_COUNT = 4096;

	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int FREE_W = $clog2(NODE_COUNT + 1);
	localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
	localparam int LINK_W = 2 * NODE_W;

	localparam int OUT_W = 31;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [1:0][NODE_W-1:0] link_t;

	// Port request from the walker to the node memory
	typedef struct packed {
		logic  rd_en;
		node_t rd_addr;
		logic  wr_en;
		node_t wr_addr;
		link_t wr_data;
	} mem_req_t;

endpackage

@@ rtl/core/binary_trie_max_xor.sv @@
// A start transfer is taken when busy is low; the done strobe is registered from the walker's
// finish once every key level has been walked, an allocating insert also writing its leaf node.
// A query dead end or an exhausted pool ends the walk early. One node memory read or write
// per key level sets the pace; a new start is taken in the cycle that done is shown.
// Reset (arst_n low, asynchronous) empties the trie: root reads as empty, free pointer is 1.
module binary_trie_max_xor
	import btmx_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             kind,
	input  logic [OUT_W-1:0] key,
	output logic             done,
	output logic [OUT_W-1:0] max_xor,
	output logic             pool_full
);

	mem_req_t req;
	link_t    rd_data;

	// Walker: one trie level per cycle, read of the next node issued from
	// the current node's links so the walk never waits on the memory
	btmx_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.kind      (kind),
		.key       (key),
		.busy      (busy),
		.req       (req),
		.rd_data   (rd_data),
		.done      (done),
		.max_xor   (max_xor),
		.pool_full (pool_full)
	);

	// Node pool: two child links per node, index 0 meaning no child
	btmx_node_ram #(
		.DEPTH (NODE_COUNT),
		.WIDTH (LINK_W)
	) u_node_ram (
		.clk     (clk),
		.rd_en   (req.rd_en),
		.rd_addr (req.rd_addr),
		.rd_data (rd_data),
		.wr_en   (req.wr_en),
		.wr_addr (req.wr_addr),
		.wr_data (req.wr_data)
	);

endmodule

@@ rtl/core/btmx_node_ram.sv @@
// Simple dual-port node memory, one write and one registered read per cycle.
module btmx_node_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/btmx_walk.sv @@
// Level walker: steps one key bit per cycle, allocates nodes and builds the XOR.
module btmx_walk
	import btmx_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                kind,
	input  logic [OUT_W-1:0]    key,
	output logic                busy,
	output mem_req_t            req,
	input  link_t               rd_data,
	output logic                done,
	output logic [OUT_W-1:0]    max_xor,
	output logic                pool_full
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_WALK  = 3'b010,
		S_FRESH = 3'b100
	} state_t;

	state_t              state_q, state_d;
	logic                kind_q;
	logic [KEY_BITS-1:0] key_q;
	logic [LVL_W-1:0]    lvl_q, lvl_d;
	node_t               node_q, node_d;
	logic [KEY_BITS-1:0] acc_q, acc_d;
	logic [FREE_W-1:0]   free_q, free_d;
	logic                leaf_q, leaf_d;
	logic                root_ok_q;
	logic                rd_root_q;
	logic                done_q;
	logic [OUT_W-1:0]    max_xor_q;
	logic                pool_full_q;

	link_t links;
	logic  bit_k;
	node_t same, opp, nxt, new_node;
	logic  pool_dry, lvl_last, step, fin, full_d;

	// Root entry reads as empty until first written
	assign links    = (rd_root_q && !root_ok_q) ? '0 : rd_data;
	assign bit_k    = key_q[lvl_q];
	assign same     = links[bit_k];
	assign opp      = links[~bit_k];
	assign pool_dry = (free_q == FREE_W'(NODE_COUNT));
	assign lvl_last = (lvl_q == '0);
	assign new_node = free_q[NODE_W-1:0];

	always_comb begin
		state_d = state_q;
		lvl_d   = lvl_q;
		node_d  = node_q;
		acc_d   = acc_q;
		free_d  = free_q;
		leaf_d  = leaf_q;
		req     = '0;
		nxt     = same;
		step    = 1'b0;
		fin     = 1'b0;
		full_d  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req.rd_en   = 1'b1;
					req.rd_addr = '0;
					node_d      = '0;
					lvl_d       = LVL_W'(KEY_BITS - 1);
					acc_d       = '0;
					state_d     = S_WALK;
				end
			end
			S_WALK: begin
				if (kind_q == KIND_QUERY) begin
					if (opp != '0) begin
						acc_d = acc_q | (KEY_BITS'(1) << lvl_q);
						nxt   = opp;
						step  = 1'b1;
					end else if (same != '0) begin
						step = 1'b1;
					end else begin
						fin = 1'b1;    // dead end of a partial path
					end
				end else if (same != '0) begin
					step = 1'b1;
				end else if (pool_dry) begin
					fin    = 1'b1;
					full_d = 1'b1;
				end else begin
					req.wr_en          = 1'b1;
					req.wr_addr        = node_q;
					req.wr_data        = links;
					req.wr_data[bit_k] = new_node;
					node_d             = new_node;
					free_d             = free_q + 1'b1;
					state_d            = S_FRESH;
					leaf_d             = lvl_last;
					if (!lvl_last) begin
						lvl_d = lvl_q - 1'b1;
					end
				end
				if (step) begin
					node_d = nxt;
					if (lvl_last) begin
						fin = 1'b1;
					end else begin
						req.rd_en   = 1'b1;
						req.rd_addr = nxt;
						lvl_d       = lvl_q - 1'b1;
					end
				end
			end
			S_FRESH: begin
				// Fresh node: links known empty, no read needed
				req.wr_en   = 1'b1;
				req.wr_addr = node_q;
				req.wr_data = '0;
				if (leaf_q || pool_dry) begin
					fin    = 1'b1;
					full_d = !leaf_q;
				end else begin
					req.wr_data[bit_k] = new_node;
					node_d             = new_node;
					free_d             = free_q + 1'b1;
					leaf_d             = lvl_last;
					if (!lvl_last) begin
						lvl_d = lvl_q - 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_q      <= FREE_W'(1);
			root_ok_q   <= 1'b0;
			rd_root_q   <= 1'b0;
			done_q      <= 1'b0;
			leaf_q      <= 1'b0;
		end else begin
			state_q   <= state_d;
			free_q    <= free_d;
			leaf_q    <= leaf_d;
			rd_root_q <= req.rd_en && (req.rd_addr == '0);
			done_q    <= fin;
			if (req.wr_en && (req.wr_addr == '0)) begin
				root_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		lvl_q  <= lvl_d;
		node_q <= node_d;
		acc_q  <= acc_d;
		if (state_q == S_IDLE && start) begin
			kind_q <= kind;
			key_q  <= KEY_BITS'(key);
		end
		if (fin) begin
			max_xor_q   <= (kind_q == KIND_QUERY) ? OUT_W'(acc_d) : '0;
			pool_full_q <= full_d;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign max_xor   = max_xor_q;
	assign pool_full = pool_full_q;

`ifndef SYNTHESIS
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FREE_W'(NODE_COUNT))
		else $error("free pointer beyond pool");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(req.wr_en && req.rd_en) |-> (req.wr_addr != req.rd_addr))
		else $error("read and write to the same node in one cycle");

	a_fresh_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FRESH) |-> (node_q != '0))
		else $error("fresh node aliases the root");

	a_done_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) != S_IDLE) && (state_q == S_IDLE))
		else $error("result strobe without a finished walk");
`endif

endmodule

@@ sim/tb_binary_trie_max_xor.sv @@
// Testbench for the maximum-XOR binary trie: directed and random inserts and queries
`timescale 1ns / 1ps

module tb_binary_trie_max_xor;
	import btmx_pkg::*;

	typedef struct {
		logic [OUT_W-1:0] max_xor;
		logic             pool_full;
	} trie_result_t;

	// Scoreboard: keeps its own copy of the trie and checks each result transfer in order.
	class xor_trie_board;
		bit [NODE_W-1:0] kids[NODE_COUNT][2];  // child links; 0 means no child
		int unsigned     next_node;
		trie_result_t    due_results[$];
		int unsigned     errors;
		bit              has_partial;          // an insert ran dry part way down
		logic [OUT_W-1:0] partial_key;

		function new();
			next_node   = 1;
			errors      = 0;
			has_partial = 0;
			partial_key = '0;
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		// An input transfer was taken: walk the local trie and queue what should come back.
		function void note_transfer(logic k_kind, logic [OUT_W-1:0] k_key);
			trie_result_t    res;
			bit [NODE_W-1:0] node;
			bit [NODE_W-1:0] nxt;
			int unsigned     grabbed;
			bit              b;
			res.max_xor   = '0;
			res.pool_full = 1'b0;
			node          = '0;
			grabbed       = 0;
			if (k_kind == KIND_INSERT) begin
				for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
					b   = k_key[lvl];
					nxt = kids[node][b];
					if (nxt == 0) begin
						if (next_node >= NODE_COUNT) begin
							res.pool_full = 1'b1;
							break;
						end
						nxt = NODE_W'(next_node);
						next_node++;
						grabbed++;
						kids[nxt][0] = '0;
						kids[nxt][1] = '0;
						kids[node][b] = nxt;
					end
					node = nxt;
				end
				// partial path left behind: a query on its complement will hit the dead end
				if (res.pool_full && grabbed != 0) begin
					has_partial = 1;
					partial_key = k_key;
				end
			end else begin
				for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
					b = k_key[lvl];
					if (kids[node][!b] != 0) begin
						res.max_xor[lvl] = 1'b1;
						node = kids[node][!b];
					end else if (kids[node][b] != 0) begin
						node = kids[node][b];
					end else begin
						break;
					end
				end
			end
			due_results.push_back(res);
		endfunction

		function void check_result(logic [OUT_W-1:0] got_xor, logic got_full);
			trie_result_t want;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result max_xor %h pool_full %b", $time,
					got_xor, got_full);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got_xor !== want.max_xor) begin
				$display("%0t: max_xor expected %h actual %h", $time, want.max_xor, got_xor);
				errors++;
			end
			if (got_full !== want.pool_full) begin
				$display("%0t: pool_full expected %b actual %b", $time, want.pool_full,
					got_full);
				errors++;
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             kind;
	logic [OUT_W-1:0] key;
	logic             done;
	logic [OUT_W-1:0] max_xor;
	logic             pool_full;

	xor_trie_board    sb;
	int unsigned      gap_pct;     // chance per cycle that the sender holds off
	logic [OUT_W-1:0] stored[$];   // recent insert keys, to steer random keys onto live paths

	localparam logic [OUT_W-1:0] ALL_ONES = '1;

	binary_trie_max_xor dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.key       (key),
		.done      (done),
		.max_xor   (max_xor),
		.pool_full (pool_full)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous cap: ~900 items, plus sender gaps, finish well inside it.
	initial begin
		#4ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Monitor: results are checked before the new start is noted, since a start can be
	// taken in the very cycle that done is shown.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(max_xor, pool_full);
			if (start && !busy)
				sb.note_transfer(kind, key);
		end
	end

	// Present one item from a falling edge and hold it until a rising edge sees busy low.
	// While the sender idles, start is low and the payload carries junk.
	task automatic send_item(input logic k_kind, input logic [OUT_W-1:0] k_key);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			kind  <= 1'($urandom_range(1));
			key   <= OUT_W'($urandom());
			@(negedge clk);
		end
		start <= 1'b1;
		kind  <= k_kind;
		key   <= k_key;
		do
			@(posedge clk);
		while (busy);
		if (k_kind == KIND_INSERT) begin
			stored.push_back(k_key);
			if (stored.size() > 64)
				void'(stored.pop_front());
		end
	endtask

	function automatic logic [OUT_W-1:0] any_stored();
		if (stored.size() == 0)
			return OUT_W'($urandom());
		return stored[$urandom_range(stored.size() - 1)];
	endfunction

	function automatic logic [OUT_W-1:0] low_flip();
		logic [OUT_W-1:0] m;
		m = OUT_W'((1 << $urandom_range(8, 1)) - 1);
		return OUT_W'($urandom()) & m;
	endfunction

	function automatic logic [OUT_W-1:0] edge_key();
		case ($urandom_range(3))
			0:       return '0;
			1:       return ALL_ONES;
			2:       return OUT_W'(1) << $urandom_range(OUT_W - 1);
			default: return ~(OUT_W'(1) << $urandom_range(OUT_W - 1));
		endcase
	endfunction

	// Random item: keys mostly track what is already in the trie so that queries walk deep
	// and inserts share prefixes; fresh random keys drain the pool part way through.
	task automatic send_random();
		int unsigned      pick;
		logic [OUT_W-1:0] k;
		pick = $urandom_range(99);
		if ($urandom_range(1) == 0) begin
			if (pick < 45)
				k = OUT_W'($urandom());
			else if (pick < 70)
				k = any_stored() ^ low_flip();
			else if (pick < 90)
				k = any_stored();
			else
				k = edge_key();
			send_item(KIND_INSERT, k);
		end else begin
			if (pick < 25)
				k = OUT_W'($urandom());
			else if (pick < 55)
				k = ~any_stored();
			else if (pick < 70)
				k = any_stored() ^ low_flip();
			else if (pick < 85)
				k = sb.has_partial ? ~(sb.partial_key ^ low_flip()) : edge_key();
			else if (pick < 93)
				k = any_stored();
			else
				k = edge_key();
			send_item(KIND_QUERY, k);
		end
	endtask

	initial begin
		sb      = new();
		gap_pct = 0;
		arst_n  = 1'b0;
		start   = 1'b0;
		kind    = KIND_INSERT;
		key     = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty trie, extremes, duplicates, single-bit and top-bit keys
		send_item(KIND_QUERY,  '0);
		send_item(KIND_QUERY,  ALL_ONES);
		send_item(KIND_INSERT, '0);
		send_item(KIND_QUERY,  '0);
		send_item(KIND_QUERY,  ALL_ONES);
		send_item(KIND_INSERT, ALL_ONES);
		send_item(KIND_QUERY,  '0);
		send_item(KIND_QUERY,  31'h2AAA_AAAA);
		send_item(KIND_INSERT, '0);
		send_item(KIND_INSERT, 31'h5555_5555);
		send_item(KIND_QUERY,  31'h5555_5555);
		send_item(KIND_QUERY,  31'h2AAA_AAAA);
		send_item(KIND_INSERT, 31'h0000_0001);
		send_item(KIND_QUERY,  31'h0000_0001);
		send_item(KIND_INSERT, 31'h4000_0000);
		send_item(KIND_QUERY,  31'h4000_0000);
		send_item(KIND_QUERY,  31'h3FFF_FFFF);
		send_item(KIND_INSERT, ALL_ONES);
		send_item(KIND_QUERY,  31'h7FFF_FFFE);
		send_item(KIND_QUERY,  31'h0000_0001);

		// random: sender gaps 12 %, then 50 %, then back to back
		gap_pct = 12;
		repeat (300) send_random();
		gap_pct = 50;
		repeat (300) send_random();
		gap_pct = 0;
		repeat (300) send_random();

		@(negedge clk);
		start <= 1'b0;

		// drain, then watch a while longer for stray done strobes
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (2 * (KEY_BITS + 2)) @(posedge clk);

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
